// ----- src/sarlc_pkg.sv -----
// Shared types and constants for the serial converter readout and level classifier.
package sarlc_pkg;

  localparam int NUM_THRESH = 5;
  localparam int THRESH_W   = 24;
  localparam int VALUE_W    = 24;
  localparam int LEVEL_W    = 3;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  typedef logic [THRESH_W-1:0]                  thresh_t;
  typedef thresh_t [NUM_THRESH-1:0]             thresh_arr_t;
  typedef logic [LEVEL_W-1:0]                   level_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_FOUR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH_FIVE  = 3'd4;

  localparam thresh_arr_t THRESH_RESET = {
    24'd200000, 24'd190000, 24'd180000, 24'd170000, 24'd160000
  };

  localparam level_t LEVEL_NONE  = 3'd0;
  localparam level_t LEVEL_ONE   = 3'd1;
  localparam level_t LEVEL_TWO   = 3'd2;
  localparam level_t LEVEL_THREE = 3'd3;
  localparam level_t LEVEL_FOUR  = 3'd4;
  localparam level_t LEVEL_FIVE  = 3'd5;

endpackage

// ----- src/sarlc_classify.sv -----
// Sign extension of the shifted-in reading and threshold level classification.
module sarlc_classify
  import sarlc_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic [SAMPLE_BITS-1:0] raw,
  input  thresh_arr_t            thresh,
  output logic [VALUE_W-1:0]     value,
  output level_t                 level
);

  localparam int CW = (SAMPLE_BITS > THRESH_W) ? SAMPLE_BITS : THRESH_W;
  localparam logic [SAMPLE_BITS-1:0] SIGN_CODE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] POS_RAIL  = ~SIGN_CODE;

  logic signed [CW-1:0] v_ext;
  logic signed [CW-1:0] t_ext [NUM_THRESH];
  logic                 rail;

  assign v_ext = CW'($signed(raw));

  always_comb begin
    for (int i = 0; i < NUM_THRESH; i++) begin
      t_ext[i] = CW'($signed(thresh[i]));
    end
  end

  assign rail  = (raw == POS_RAIL) || (raw == SIGN_CODE);
  assign value = v_ext[VALUE_W-1:0];

  // level none below threshold one; else tested top down, highest met wins
  always_comb begin
    if (v_ext < t_ext[0] || rail) begin
      level = LEVEL_NONE;
    end else if (v_ext >= t_ext[4]) begin
      level = LEVEL_FIVE;
    end else if (v_ext >= t_ext[3]) begin
      level = LEVEL_FOUR;
    end else if (v_ext >= t_ext[2]) begin
      level = LEVEL_THREE;
    end else if (v_ext >= t_ext[1]) begin
      level = LEVEL_TWO;
    end else begin
      level = LEVEL_ONE;
    end
  end

endmodule

// ----- src/serial_adc_reader_level_classifier.sv -----
// Top level: serial converter readout sequencer, result register and threshold registers.
//
//  channel | direction | ports                         | handshake
//  --------+-----------+-------------------------------+-------------------------
//  in      | input     | in_data_pin                   | in_valid / in_stall
//  out     | output    | out_clock_out, out_sample_*,  | out_valid / out_stall
//          |           | out_fill_level                |
//  cfg     | APB slave | cfg_p*                        | psel / penable, pready=1
//
// One beat in, one registered beat out; a beat can be taken every cycle unless stalled.
// A full sample takes 2*SAMPLE_BITS+2 input beats from the ready tick to delivery.
// Synchronous active-low reset returns the sequencer to idle and thresholds to defaults.
// in_stall is raised only while the result register holds a beat that out_stall holds.
module serial_adc_reader_level_classifier
  import sarlc_pkg::*;
#(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_data_pin,
  // result channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_clock_out,
  output logic                  out_sample_ready,
  output logic [VALUE_W-1:0]    out_sample_value,
  output logic [LEVEL_W-1:0]    out_fill_level,
  // configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int BCW = $clog2(SAMPLE_BITS + 1);
  localparam logic [BCW-1:0] BITS_TOTAL = BCW'(SAMPLE_BITS);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HIGH,
    PH_LOW,
    PH_EXTRA
  } phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [BCW-1:0]           bit_count_r, bit_count_nxt;
  logic [SAMPLE_BITS-1:0]   shift_reg_r, shift_reg_nxt;
  thresh_arr_t              thresh_r;

  logic                     out_valid_r;
  logic                     clock_out_r, clock_nxt;
  logic                     ready_r, ready_nxt;
  logic [VALUE_W-1:0]       value_r, value_nxt;
  level_t                   level_r, level_nxt;

  logic                     in_fire;
  logic                     cfg_wr;
  logic [CFG_IDX_W-1:0]     cfg_idx;
  logic [VALUE_W-1:0]       cls_value;
  level_t                   cls_level;

  assign in_stall = out_valid_r & out_stall;
  assign in_fire  = in_valid & ~in_stall;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_idx)
      REG_THRESH_ONE, REG_THRESH_TWO, REG_THRESH_THREE,
      REG_THRESH_FOUR, REG_THRESH_FIVE: begin
        cfg_prdata = CFG_DATA_W'($signed(thresh_r[cfg_idx]));
      end
      default: begin
        cfg_prdata = '0;
      end
    endcase
  end

  sarlc_classify #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_classify (
    .raw    (shift_reg_r),
    .thresh (thresh_r),
    .value  (cls_value),
    .level  (cls_level)
  );

  always_comb begin
    phase_nxt     = phase_r;
    bit_count_nxt = bit_count_r;
    shift_reg_nxt = shift_reg_r;
    clock_nxt     = 1'b0;
    ready_nxt     = 1'b0;
    value_nxt     = '0;
    level_nxt     = LEVEL_NONE;
    case (phase_r)
      PH_IDLE: begin
        // data line low means a conversion is waiting
        if (!in_data_pin) begin
          clock_nxt     = 1'b1;
          bit_count_nxt = '0;
          shift_reg_nxt = '0;
          phase_nxt     = PH_HIGH;
        end
      end
      PH_HIGH: begin
        shift_reg_nxt = {shift_reg_r[SAMPLE_BITS-2:0], in_data_pin};
        bit_count_nxt = bit_count_r + 1'b1;
        phase_nxt     = PH_LOW;
      end
      PH_LOW: begin
        clock_nxt = 1'b1;
        phase_nxt = (bit_count_r < BITS_TOTAL) ? PH_HIGH : PH_EXTRA;
      end
      PH_EXTRA: begin
        ready_nxt = 1'b1;
        value_nxt = cls_value;
        level_nxt = cls_level;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      bit_count_r <= '0;
      shift_reg_r <= '0;
      thresh_r    <= THRESH_RESET;
      out_valid_r <= 1'b0;
      clock_out_r <= 1'b0;
      ready_r     <= 1'b0;
      value_r     <= '0;
      level_r     <= LEVEL_NONE;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          REG_THRESH_ONE, REG_THRESH_TWO, REG_THRESH_THREE,
          REG_THRESH_FOUR, REG_THRESH_FIVE: begin
            thresh_r[cfg_idx] <= cfg_pwdata[THRESH_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_fire) begin
        phase_r     <= phase_nxt;
        bit_count_r <= bit_count_nxt;
        shift_reg_r <= shift_reg_nxt;
        out_valid_r <= 1'b1;
        clock_out_r <= clock_nxt;
        ready_r     <= ready_nxt;
        value_r     <= value_nxt;
        level_r     <= level_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_clock_out    = clock_out_r;
  assign out_sample_ready = ready_r;
  assign out_sample_value = value_r;
  assign out_fill_level   = level_r;

endmodule
